[rtl/jse_pkg.sv]
// jse_pkg: item types, queue entry type and character constants for the
// JSON string escaper. Depends on nothing; used by every rtl/jse_* file.
package jse_pkg;

  typedef struct packed {
    logic [20:0] code_point;
    logic        no_char;
    logic        starts_string;
    logic        ends_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } out_item_t;

  localparam int MAX_BYTES = 8;

  // One queued item: its bytes in send order (bytes[0] first) and count - 1.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                len_m1;
  } entry_t;

  // Configuration port
  localparam int         PADDR_W       = 3;
  localparam logic       REG_BYTE_MODE = 1'b0;   // register index, paddr[2]

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_A_LOW  = 8'h61;

  // Range limits and UTF-8 byte marks
  localparam logic [20:0] CTRL_LIMIT  = 21'h00020;
  localparam logic [20:0] ASCII_LIMIT = 21'h00080;
  localparam logic [20:0] TWO_LIMIT   = 21'h00800;
  localparam logic [20:0] THREE_LIMIT = 21'h10000;
  localparam logic [7:0]  LEAD2       = 8'hC0;
  localparam logic [7:0]  LEAD3       = 8'hE0;
  localparam logic [7:0]  LEAD4       = 8'hF0;
  localparam logic [7:0]  CONT        = 8'h80;

endpackage

[rtl/jse_front.sv]
// jse_front: accepts an item and classifies it into its complete byte
// sequence (quotes, escape or UTF-8). Depends on jse_pkg.
module jse_front (
  input  logic              start,
  input  logic              busy,
  input  logic              byte_mode,
  input  jse_pkg::in_item_t in_item,
  output logic              push,
  output jse_pkg::entry_t   entry
);

  logic [20:0]     c;
  logic [7:0]      lo;
  logic            hi_zero;
  logic [5:0][7:0] cb;     // character bytes
  logic [2:0]      cn;     // character byte count, 0..6
  logic [3:0]      n;      // total byte count, 0..8
  logic            opens;
  logic            closes;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    hex_digit = (v < 4'd10) ? (jse_pkg::CH_ZERO + {4'd0, v})
                            : (jse_pkg::CH_A_LOW + {4'd0, v} - 8'd10);
  endfunction

  assign opens  = in_item.starts_string;
  assign closes = in_item.ends_string;

  always_comb begin
    c       = byte_mode ? {13'd0, in_item.code_point[7:0]} : in_item.code_point;
    lo      = c[7:0];
    hi_zero = (c[20:8] == 13'd0);
    cb      = '0;
    cn      = 3'd0;
    if (!in_item.no_char) begin
      if (hi_zero && (lo == jse_pkg::CH_QUOTE || lo == jse_pkg::CH_BSLASH)) begin
        cb[0] = jse_pkg::CH_BSLASH; cb[1] = lo; cn = 3'd2;
      end else if (hi_zero && lo == jse_pkg::CH_LF) begin
        cb[0] = jse_pkg::CH_BSLASH; cb[1] = jse_pkg::CH_N; cn = 3'd2;
      end else if (hi_zero && lo == jse_pkg::CH_CR) begin
        cb[0] = jse_pkg::CH_BSLASH; cb[1] = jse_pkg::CH_R; cn = 3'd2;
      end else if (hi_zero && lo == jse_pkg::CH_TAB) begin
        cb[0] = jse_pkg::CH_BSLASH; cb[1] = jse_pkg::CH_T; cn = 3'd2;
      end else if (c < jse_pkg::CTRL_LIMIT) begin
        cb[0] = jse_pkg::CH_BSLASH;
        cb[1] = jse_pkg::CH_U;
        cb[2] = jse_pkg::CH_ZERO;
        cb[3] = jse_pkg::CH_ZERO;
        cb[4] = hex_digit(c[7:4]);
        cb[5] = hex_digit(c[3:0]);
        cn    = 3'd6;
      end else if (byte_mode || c < jse_pkg::ASCII_LIMIT) begin
        cb[0] = lo; cn = 3'd1;
      end else if (c < jse_pkg::TWO_LIMIT) begin
        cb[0] = jse_pkg::LEAD2 | {3'd0, c[10:6]};
        cb[1] = jse_pkg::CONT | {2'd0, c[5:0]};
        cn    = 3'd2;
      end else if (c < jse_pkg::THREE_LIMIT) begin
        cb[0] = jse_pkg::LEAD3 | {4'd0, c[15:12]};
        cb[1] = jse_pkg::CONT | {2'd0, c[11:6]};
        cb[2] = jse_pkg::CONT | {2'd0, c[5:0]};
        cn    = 3'd3;
      end else begin
        cb[0] = jse_pkg::LEAD4 | {5'd0, c[20:18]};
        cb[1] = jse_pkg::CONT | {2'd0, c[17:12]};
        cb[2] = jse_pkg::CONT | {2'd0, c[11:6]};
        cb[3] = jse_pkg::CONT | {2'd0, c[5:0]};
        cn    = 3'd4;
      end
    end
  end

  assign n = {3'd0, opens} + {1'b0, cn} + {3'd0, closes};

  // Lay out opening quote, character bytes and closing quote.
  always_comb begin
    entry.bytes = '0;
    for (int k = 0; k < jse_pkg::MAX_BYTES; k++) begin
      if (opens && k == 0) begin
        entry.bytes[k] = jse_pkg::CH_QUOTE;
      end else if ((4'(k) - {3'd0, opens}) < {1'b0, cn}) begin
        entry.bytes[k] = cb[3'(4'(k) - {3'd0, opens})];
      end else if (closes && (4'(k) - {3'd0, opens}) == {1'b0, cn}) begin
        entry.bytes[k] = jse_pkg::CH_QUOTE;
      end
    end
    entry.len_m1 = 3'(n - 4'd1);
  end

  // Items that produce no byte never enter the queue.
  assign push = start && !busy && (n != 4'd0);

endmodule

[rtl/jse_fifo.sv]
// jse_fifo: short queue of classified items between front and back.
// Depends on jse_pkg.
module jse_fifo #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  jse_pkg::entry_t push_data,
  input  logic            pop,
  output jse_pkg::entry_t head,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jse_pkg::entry_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? bump(rd_ptr_r) : rd_ptr_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign head  = mem[rd_ptr_r];
  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("pop from empty queue");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count lost a push");

endmodule

[rtl/jse_back.sv]
// jse_back: takes queued items and sends their bytes one per cycle through
// a registered strobe output. Depends on jse_pkg.
module jse_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  jse_pkg::entry_t    head,
  output logic               pop,
  output logic               out_valid,
  output jse_pkg::out_item_t out_item
);

  jse_pkg::entry_t    cur_r, cur_nxt;
  logic [2:0]         idx_r, idx_nxt;
  logic               active_r, active_nxt;
  logic               out_valid_r;
  jse_pkg::out_item_t out_item_r;
  logic               last_now;

  assign last_now = active_r && (idx_r == cur_r.len_m1);
  // Next item loads in the cycle that sends the last byte of this one.
  assign pop      = !empty && (!active_r || last_now);

  always_comb begin
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    active_nxt = active_r;
    if (pop) begin
      cur_nxt    = head;
      idx_nxt    = 3'd0;
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (last_now) begin
        active_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    cur_r                   <= cur_nxt;
    idx_r                   <= idx_nxt;
    out_item_r.out_byte     <= cur_r.bytes[idx_r];
    out_item_r.last_of_item <= last_now;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> idx_r <= cur_r.len_m1) else $error("byte index past item end");
  a_stay_active: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !last_now) |=> active_r && idx_r == $past(idx_r) + 3'd1)
    else $error("item dropped before its last byte");
  a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && active_r) |-> last_now) else $error("item replaced mid-send");

endmodule

[rtl/json_string_escape_utf8.sv]
// json_string_escape_utf8: one code point per item in, JSON string bytes out.
// Path: an accepted item passes through the item queue, the sender's item register and the output register.
// Throughput: the byte sender holds an item of 1..8 bytes until its last byte
// goes out, so plain ASCII runs at one item per cycle; busy rises when the
// item queue is full. The receiver cannot stall; each byte strobes once.
// Reset (rst_n low, synchronous): byte_mode to 0, queue and sender emptied.
module json_string_escape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // item input
  input  logic                        start,
  output logic                        busy,
  input  jse_pkg::in_item_t           in_item,
  // byte output
  output logic                        out_valid,
  output jse_pkg::out_item_t          out_item,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [jse_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic            byte_mode_r;
  logic            cfg_wr;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;
  jse_pkg::entry_t push_entry;
  jse_pkg::entry_t head_entry;

  // Register file: only byte_mode, selected by paddr[2] == 0 (byte addresses 0..3).
  // Addresses 4..7 take writes silently and read as zero.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_mode_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == jse_pkg::REG_BYTE_MODE) begin
      byte_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == jse_pkg::REG_BYTE_MODE) ? {31'd0, byte_mode_r} : 32'd0;

  // busy only reflects queue space; the front never waits on the sender.
  assign busy = full;

  // Front: classify the accepted item into its whole byte sequence.
  jse_front u_front (
    .start     (start),
    .busy      (busy),
    .byte_mode (byte_mode_r),
    .in_item   (in_item),
    .push      (push),
    .entry     (push_entry)
  );

  // Queue decouples classification from byte sending.
  jse_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_entry),
    .pop       (pop),
    .head      (head_entry),
    .full      (full),
    .empty     (empty)
  );

  // Back: one byte per cycle, last_of_item on each item's final byte.
  jse_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .head      (head_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

[bench/tb_json_string_escape_utf8.sv]
// tb_json_string_escape_utf8: self-checking bench for the JSON string escaper.
// Drives items and APB register writes, and checks every output byte against predicted or literal expectations.
// Depends on rtl/jse_pkg.sv and rtl/json_string_escape_utf8.sv.
module tb_json_string_escape_utf8;
  timeunit 1ns;
  timeprecision 1ps;

  // Timing and run length
  localparam int CYCLE_LIMIT  = 100000; // far above the slowest legal run
  localparam int SETTLE_CYCLS = 12;     // well above the output latency
  localparam int MAX_REPORTS  = 30;
  localparam int PREDICT      = -1;     // table row checked by the predictor

  // Register map: byte_mode at index 0; index 1 is unmapped and must be ignored
  localparam logic [jse_pkg::PADDR_W-1:0] BYTE_MODE_ADDR = {jse_pkg::REG_BYTE_MODE, 2'b00};
  localparam logic [jse_pkg::PADDR_W-1:0] SPARE_ADDR     = {~jse_pkg::REG_BYTE_MODE, 2'b00};

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  jse_pkg::in_item_t           in_item;
  logic                        out_valid;
  jse_pkg::out_item_t          out_item;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [jse_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  json_string_escape_utf8 dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bench-side copy of the register and the bytes still owed by the block
  logic               byte_mode_shadow;
  jse_pkg::out_item_t expected_bytes[$];
  int                 err_count   = 0;
  int                 items_sent  = 0;
  int                 bytes_seen  = 0;
  int                 cycle_count = 0;

  // --------------------------------------------------------------------------
  // Escaper prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(logic [3:0] v);
    return (v < 4'd10) ? jse_pkg::CH_ZERO + 8'(v) : jse_pkg::CH_A_LOW + 8'(v - 4'd10);
  endfunction

  // Queues the bytes one item produces; the final byte carries last_of_item.
  function automatic void predict_escape(jse_pkg::in_item_t it);
    logic [20:0]        c;
    logic [7:0]         seq[$];
    jse_pkg::out_item_t o;
    c = it.code_point;
    if (byte_mode_shadow) c = c & 21'h0000FF;    // byte strings use the low byte only
    if (it.starts_string) seq.push_back(jse_pkg::CH_QUOTE);
    if (!it.no_char) begin
      if (c == 21'(jse_pkg::CH_QUOTE) || c == 21'(jse_pkg::CH_BSLASH)) begin
        seq.push_back(jse_pkg::CH_BSLASH);
        seq.push_back(c[7:0]);
      end else if (c == 21'(jse_pkg::CH_LF)) begin
        seq.push_back(jse_pkg::CH_BSLASH);
        seq.push_back(jse_pkg::CH_N);
      end else if (c == 21'(jse_pkg::CH_CR)) begin
        seq.push_back(jse_pkg::CH_BSLASH);
        seq.push_back(jse_pkg::CH_R);
      end else if (c == 21'(jse_pkg::CH_TAB)) begin
        seq.push_back(jse_pkg::CH_BSLASH);
        seq.push_back(jse_pkg::CH_T);
      end else if (c < jse_pkg::CTRL_LIMIT) begin
        // \u00XX, lower-case hex
        seq.push_back(jse_pkg::CH_BSLASH);
        seq.push_back(jse_pkg::CH_U);
        seq.push_back(jse_pkg::CH_ZERO);
        seq.push_back(jse_pkg::CH_ZERO);
        seq.push_back(hex_char({3'b000, c[4]}));
        seq.push_back(hex_char(c[3:0]));
      end else if (byte_mode_shadow || c < jse_pkg::ASCII_LIMIT) begin
        seq.push_back(c[7:0]);
      end else if (c < jse_pkg::TWO_LIMIT) begin
        seq.push_back(jse_pkg::LEAD2 | {3'b000, c[10:6]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[5:0]});
      end else if (c < jse_pkg::THREE_LIMIT) begin
        // surrogates land here too, unchecked
        seq.push_back(jse_pkg::LEAD3 | {4'b0000, c[15:12]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[11:6]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[5:0]});
      end else begin
        // lead byte keeps all three top bits, so up to 0xF7
        seq.push_back(jse_pkg::LEAD4 | {5'b00000, c[20:18]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[17:12]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[11:6]});
        seq.push_back(jse_pkg::CONT | {2'b00, c[5:0]});
      end
    end
    if (it.ends_string) seq.push_back(jse_pkg::CH_QUOTE);
    foreach (seq[i]) begin
      o.out_byte     = seq[i];
      o.last_of_item = (i == seq.size() - 1);
      expected_bytes.push_back(o);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output checker: every strobed byte must match the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    jse_pkg::out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      bytes_seen++;
      if (expected_bytes.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: unexpected byte %02h (last=%0b), nothing pending",
                   $time, out_item.out_byte, out_item.last_of_item);
      end else begin
        want = expected_bytes.pop_front();
        if (out_item.out_byte !== want.out_byte) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: out_byte mismatch: expected %02h, got %02h",
                     $time, want.out_byte, out_item.out_byte);
        end
        if (out_item.last_of_item !== want.last_of_item) begin
          err_count++;
          if (err_count <= MAX_REPORTS)
            $display("%0t: last_of_item mismatch on byte %02h: expected %0b, got %0b",
                     $time, want.out_byte, want.last_of_item, out_item.last_of_item);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d bytes still pending",
               $time, cycle_count, expected_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers; every task starts and ends just after a falling edge
  // --------------------------------------------------------------------------

  // Offers one item and holds it until the block takes it. n_typed >= 0 means
  // the expected bytes are given literally, first byte in the upper end.
  task automatic send_item(jse_pkg::in_item_t it, int n_typed, logic [63:0] typed);
    jse_pkg::out_item_t o;
    start   = 1'b1;
    in_item = it;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (n_typed == PREDICT) begin
      predict_escape(it);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        o.out_byte     = typed[8*(n_typed-1-i) +: 8];
        o.last_of_item = (i == n_typed - 1);
        expected_bytes.push_back(o);
      end
    end
    items_sent++;
    @(negedge clk);
  endtask

  // Sender idle burst; the item bus carries junk that must be ignored
  task automatic rest(int n);
    start   = 1'b0;
    in_item = jse_pkg::in_item_t'($urandom);
    repeat (n) @(negedge clk);
  endtask

  task automatic maybe_rest(bit idling);
    if (idling && $urandom_range(0, 3) == 0) rest($urandom_range(1, 16));
  endtask

  // Waits for the last byte, then idles so a stray extra byte gets caught
  task automatic drain();
    start = 1'b0;
    while (expected_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLS) @(negedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(logic [jse_pkg::PADDR_W-1:0] addr, logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[2] == jse_pkg::REG_BYTE_MODE) byte_mode_shadow = data[0];
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // APB read of byte_mode, checked against the shadow copy
  task automatic cfg_check_byte_mode();
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = BYTE_MODE_ADDR;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    if (got !== {31'b0, byte_mode_shadow}) begin
      err_count++;
      $display("%0t: byte_mode readback mismatch: expected %08h, got %08h",
               $time, {31'b0, byte_mode_shadow}, got);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Code point drawn across the escape and UTF-8 length classes
  function automatic logic [20:0] pick_code_point();
    case ($urandom_range(0, 9))
      0:       return 21'($urandom_range(0, 31));               // control
      1: begin
        case ($urandom_range(0, 4))
          0: return 21'(jse_pkg::CH_QUOTE);
          1: return 21'(jse_pkg::CH_BSLASH);
          2: return 21'(jse_pkg::CH_LF);
          3: return 21'(jse_pkg::CH_CR);
          default: return 21'(jse_pkg::CH_TAB);
        endcase
      end
      2, 3:    return 21'($urandom_range(32, 127));             // ASCII
      4:       return 21'($urandom_range(128, 255));            // Latin-1 / raw bytes
      5:       return 21'($urandom_range(256, 16'h07FF));       // two bytes
      6:       return 21'($urandom_range(16'h0800, 16'hFFFF));  // three bytes
      7:       return 21'($urandom_range(16'hD800, 16'hDFFF));  // surrogates
      8:       return 21'($urandom_range(17'h10000, 21'h1FFFFF)); // four bytes
      default: return 21'($urandom);                            // anything
    endcase
  endfunction

  // One well-formed string: opening quote on the first item, closing on the last
  task automatic send_string(bit idling);
    jse_pkg::in_item_t it;
    int                len;
    len = $urandom_range(0, 6);
    if (len == 0) begin
      // empty string "" rides on an item that carries no character
      it.code_point    = 21'($urandom);
      it.no_char       = 1'b1;
      it.starts_string = 1'b1;
      it.ends_string   = 1'b1;
      send_item(it, PREDICT, '0);
      maybe_rest(idling);
    end
    for (int i = 0; i < len; i++) begin
      it.code_point    = pick_code_point();
      it.no_char       = 1'b0;
      it.starts_string = (i == 0);
      it.ends_string   = (i == len - 1);
      send_item(it, PREDICT, '0);
      maybe_rest(idling);
    end
  endtask

  // Mostly strings, some fully random items as noise
  task automatic run_random(int n_items, bit idling);
    int first;
    first = items_sent;
    while (items_sent - first < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        send_item(jse_pkg::in_item_t'($urandom), PREDICT, '0);
        maybe_rest(idling);
      end else begin
        send_string(idling);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Directed table, UTF-8 mode straight out of reset
  // --------------------------------------------------------------------------
  typedef struct {
    jse_pkg::in_item_t item;
    int                n_bytes;   // PREDICT or number of literal bytes
    logic [63:0]       bytes;     // first byte most significant
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic void add_row(logic [20:0] cp, bit nc, bit sq, bit eq,
                                  int n, logic [63:0] b);
    dir_row_t r;
    r.item.code_point    = cp;
    r.item.no_char       = nc;
    r.item.starts_string = sq;
    r.item.ends_string   = eq;
    r.n_bytes            = n;
    r.bytes              = b;
    dir_rows.push_back(r);
  endfunction

  initial begin
    // Known values on every input from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_item          = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    byte_mode_shadow = 1'b0;

    //       code point   nc s  e   bytes  expected
    add_row(21'h000041, 0, 0, 0, 1, 64'h41);                 // plain ASCII
    add_row(21'h000000, 1, 0, 0, 0, 64'h0);                  // empty item
    add_row(21'h000000, 1, 1, 0, 1, 64'h22);                 // lone opening quote
    add_row(21'h000000, 1, 0, 1, 1, 64'h22);                 // lone closing quote
    add_row(21'h1FFFFF, 1, 1, 1, 2, 64'h2222);               // empty string, char ignored
    add_row(21'h000022, 0, 1, 1, 4, 64'h22_5C22_22);         // quoted quote
    add_row(21'h00005C, 0, 0, 0, 2, 64'h5C5C);
    add_row(21'h00000A, 0, 0, 0, 2, 64'h5C6E);
    add_row(21'h00000D, 0, 0, 0, 2, 64'h5C72);
    add_row(21'h000009, 0, 0, 0, 2, 64'h5C74);
    add_row(21'h000000, 0, 0, 0, 6, 64'h5C75_3030_3030);     // NUL
    add_row(21'h00001F, 0, 0, 0, 6, 64'h5C75_3030_3166);     // top control, hex 'f'
    add_row(21'h00001B, 0, 1, 1, 8, 64'h22_5C75_3030_3162_22); // longest item
    add_row(21'h000020, 0, 0, 0, 1, 64'h20);
    add_row(21'h00007F, 0, 0, 0, 1, 64'h7F);
    add_row(21'h000080, 0, 0, 0, 2, 64'hC280);
    add_row(21'h0007FF, 0, 0, 0, 2, 64'hDFBF);
    add_row(21'h000800, 0, 0, 0, 3, 64'hE0A080);
    add_row(21'h00D800, 0, 0, 0, 3, 64'hEDA080);             // surrogate passes through
    add_row(21'h00FFFF, 0, 0, 0, 3, 64'hEFBFBF);
    add_row(21'h010000, 0, 0, 0, 4, 64'hF0908080);
    add_row(21'h1FFFFF, 0, 1, 1, 6, 64'h22_F7BFBFBF_22);     // widest lead byte
    add_row(21'h10FFFF, 0, 1, 0, PREDICT, '0);
    add_row(21'h0003AB, 0, 0, 1, PREDICT, '0);
    add_row(21'h0000E9, 0, 1, 1, PREDICT, '0);

    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Reset value of the register, then the table back to back
    cfg_check_byte_mode();
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].n_bytes, dir_rows[i].bytes);
    drain();

    // Random UTF-8 traffic with sender gaps
    run_random(20, 1'b1);
    drain();

    // Byte mode on; a write to the unmapped index must leave it alone
    cfg_write(BYTE_MODE_ADDR, 32'd1);
    cfg_write(SPARE_ADDR, $urandom);
    cfg_check_byte_mode();
    run_random(20, 1'b1);
    drain();

    // Back to UTF-8
    cfg_write(BYTE_MODE_ADDR, 32'd0);
    cfg_write(SPARE_ADDR, 32'hFFFF_FFFF);
    cfg_check_byte_mode();
    run_random(15, 1'b1);
    drain();

    // Byte mode again, full rate with no gaps
    cfg_write(BYTE_MODE_ADDR, 32'd1);
    cfg_check_byte_mode();
    run_random(15, 1'b0);
    drain();

    $display("Sent %0d items (table plus random strings and noise), checked %0d bytes,",
             items_sent, bytes_seen);
    $display("covering UTF-8 and byte mode, unmapped register writes and readback.");
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
